// File: rtl/core/iom_pkg.sv
package iom_pkg;

  // Field widths
  localparam int unsigned CHROM_BITS      = 8;
  localparam int unsigned POS_BITS        = 32;
  localparam int unsigned SCORE_BITS      = 32;
  localparam int unsigned SCORE_FRAC_BITS = 16;
  localparam int unsigned COUNT_BITS      = 16;
  localparam int unsigned SUM_BITS        = 48;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Divider step counter
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // One piece waiting for its mean
  typedef struct packed {
    logic [CHROM_BITS-1:0] chrom;
    logic [POS_BITS-1:0]   piece_start;
    logic [POS_BITS-1:0]   piece_end;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
  } iom_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_e;

endpackage

// File: rtl/core/iom_if.sv
interface iom_in_if;
  import iom_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CHROM_BITS-1:0]        chrom_id;
  logic [POS_BITS-1:0]          position;
  logic                         is_start;
  logic signed [SCORE_BITS-1:0] score;
  logic                         last_in_set;

  modport source (output valid, chrom_id, position, is_start, score, last_in_set,
                  input ready);
  modport sink   (input valid, chrom_id, position, is_start, score, last_in_set,
                  output ready);
endinterface

interface iom_out_if;
  import iom_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CHROM_BITS-1:0]        out_chrom_id;
  logic [POS_BITS-1:0]          piece_start;
  logic [POS_BITS-1:0]          piece_end;
  logic signed [SCORE_BITS-1:0] mean_score;
  logic                         overlap_overflow;

  modport source (output valid, out_chrom_id, piece_start, piece_end, mean_score,
                  overlap_overflow, input ready);
  modport sink   (input valid, out_chrom_id, piece_start, piece_end, mean_score,
                  overlap_overflow, output ready);
endinterface

// File: rtl/core/iom_front.sv
module iom_front import iom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  iom_in_if.sink   in_i,
  input  logic     full_i,
  output logic     push_o,
  output iom_job_t job_o
);

  logic                  pv_q, pv_d;
  logic [CHROM_BITS-1:0] pc_q, pc_d;
  logic [POS_BITS-1:0]   pp_q, pp_d;
  logic                  pk_q, pk_d;
  logic [COUNT_BITS-1:0] pcnt_q, pcnt_d;
  logic [SUM_BITS-1:0]   psum_q, psum_d;
  logic [COUNT_BITS-1:0] acnt_q, acnt_d;
  logic [SUM_BITS-1:0]   asum_q, asum_d;
  logic                  ovf_q, ovf_d;

  logic                  accept;
  logic                  match;
  logic [SUM_BITS-1:0]   score_ext;
  logic [COUNT_BITS:0]   cnt_add;
  logic [COUNT_BITS-1:0] acnt_new;
  logic [SUM_BITS-1:0]   asum_new;
  logic                  ovf_new;
  logic                  emit;

  // Any accepted endpoint may close a piece, so only take one with queue room
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign score_ext = {{(SUM_BITS-SCORE_BITS){in_i.score[SCORE_BITS-1]}}, in_i.score};
  assign match     = pv_q && (pc_q == in_i.chrom_id) && (pp_q == in_i.position) &&
                     (pk_q == in_i.is_start);

  // Apply the pending endpoint to the running overlap
  always_comb begin
    cnt_add  = {1'b0, acnt_q} + {1'b0, pcnt_q};
    acnt_new = acnt_q;
    asum_new = asum_q;
    ovf_new  = ovf_q;
    if (pk_q) begin
      if (cnt_add[COUNT_BITS]) begin
        acnt_new = COUNT_MAX;
        ovf_new  = 1'b1;
      end else begin
        acnt_new = cnt_add[COUNT_BITS-1:0];
      end
      asum_new = asum_q + psum_q;
    end else begin
      if (pcnt_q > acnt_q) begin
        acnt_new = '0;
        ovf_new  = 1'b1;
      end else begin
        acnt_new = acnt_q - pcnt_q;
      end
      asum_new = asum_q - psum_q;
    end
  end

  assign emit = pv_q && !match && (acnt_new != '0) && (pc_q == in_i.chrom_id) &&
                (pp_q < in_i.position);

  // Next state
  always_comb begin
    pv_d   = pv_q;
    pc_d   = pc_q;
    pp_d   = pp_q;
    pk_d   = pk_q;
    pcnt_d = pcnt_q;
    psum_d = psum_q;
    acnt_d = acnt_q;
    asum_d = asum_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (match) begin
        if (pcnt_q == COUNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          pcnt_d = pcnt_q + 1'b1;
        end
        psum_d = psum_q + score_ext;
      end else begin
        if (pv_q) begin
          acnt_d = acnt_new;
          asum_d = asum_new;
          ovf_d  = ovf_new;
        end
        pv_d   = 1'b1;
        pc_d   = in_i.chrom_id;
        pp_d   = in_i.position;
        pk_d   = in_i.is_start;
        pcnt_d = {{(COUNT_BITS-1){1'b0}}, 1'b1};
        psum_d = score_ext;
      end
      // End of data set clears everything
      if (in_i.last_in_set) begin
        pv_d   = 1'b0;
        pc_d   = '0;
        pp_d   = '0;
        pk_d   = 1'b0;
        pcnt_d = '0;
        psum_d = '0;
        acnt_d = '0;
        asum_d = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      pc_q   <= '0;
      pp_q   <= '0;
      pk_q   <= 1'b0;
      pcnt_q <= '0;
      psum_q <= '0;
      acnt_q <= '0;
      asum_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      pv_q   <= pv_d;
      pc_q   <= pc_d;
      pp_q   <= pp_d;
      pk_q   <= pk_d;
      pcnt_q <= pcnt_d;
      psum_q <= psum_d;
      acnt_q <= acnt_d;
      asum_q <= asum_d;
      ovf_q  <= ovf_d;
    end
  end

  // Piece handed to the back end
  assign push_o            = accept && emit;
  assign job_o.chrom       = pc_q;
  assign job_o.piece_start = pp_q;
  assign job_o.piece_end   = in_i.position;
  assign job_o.sum         = asum_new;
  assign job_o.count       = acnt_new;
  assign job_o.ovf         = ovf_new;

endmodule

// File: rtl/core/iom_fifo.sv
module iom_fifo import iom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  iom_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output iom_job_t job_o,
  output logic     empty_o
);

  iom_job_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slot_q[rd_q];

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/iom_back.sv
module iom_back import iom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  iom_job_t job_i,
  output logic     pop_o,
  iom_out_if.source out_o
);

  back_state_e state_q, state_d;

  logic [STEP_BITS-1:0]  step_q;
  logic [SUM_BITS-1:0]   dvd_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] den_q;
  logic                  neg_q;
  logic [CHROM_BITS-1:0] chrom_q;
  logic [POS_BITS-1:0]   start_q, end_q;
  logic                  ovf_q;

  logic                  out_valid_q;
  logic [CHROM_BITS-1:0] out_chrom_q;
  logic [POS_BITS-1:0]   out_start_q, out_end_q;
  logic [SCORE_BITS-1:0] out_mean_q;
  logic                  out_ovf_q;

  logic                  load_job;
  logic                  load_out;
  logic                  out_free;
  logic [COUNT_BITS:0]   shifted;
  logic                  ge;
  logic [SUM_BITS-1:0]   mag;
  logic [SCORE_BITS-1:0] mean;

  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer: fetch, divide, hand over
  always_comb begin
    state_d  = state_q;
    load_job = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          load_job = 1'b1;
          state_d  = BK_RUN;
        end
      end
      BK_RUN: begin
        if (step_q == '0) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign pop_o = load_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Restoring divide of the magnitude, one quotient bit a cycle
  assign mag     = job_i.sum[SUM_BITS-1] ? (~job_i.sum + 1'b1) : job_i.sum;
  assign shifted = {rem_q, dvd_q[SUM_BITS-1]};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      dvd_q   <= mag;
      rem_q   <= '0;
      den_q   <= job_i.count;
      neg_q   <= job_i.sum[SUM_BITS-1];
      chrom_q <= job_i.chrom;
      start_q <= job_i.piece_start;
      end_q   <= job_i.piece_end;
      ovf_q   <= job_i.ovf;
      step_q  <= STEP_BITS'(SUM_BITS - 1);
    end else if (state_q == BK_RUN) begin
      rem_q  <= ge ? COUNT_BITS'(shifted - {1'b0, den_q}) : shifted[COUNT_BITS-1:0];
      dvd_q  <= {dvd_q[SUM_BITS-2:0], ge};
      step_q <= step_q - 1'b1;
    end
  end

  // Sign and saturation to the score width
  always_comb begin
    if (neg_q) begin
      if ((|dvd_q[SUM_BITS-1:SCORE_BITS]) ||
          (dvd_q[SCORE_BITS-1] && (|dvd_q[SCORE_BITS-2:0]))) begin
        mean = {1'b1, {(SCORE_BITS-1){1'b0}}};
      end else begin
        mean = ~dvd_q[SCORE_BITS-1:0] + 1'b1;
      end
    end else begin
      if (|dvd_q[SUM_BITS-1:SCORE_BITS-1]) begin
        mean = {1'b0, {(SCORE_BITS-1){1'b1}}};
      end else begin
        mean = dvd_q[SCORE_BITS-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_chrom_q <= chrom_q;
      out_start_q <= start_q;
      out_end_q   <= end_q;
      out_mean_q  <= mean;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_chrom_id     = out_chrom_q;
  assign out_o.piece_start      = out_start_q;
  assign out_o.piece_end        = out_end_q;
  assign out_o.mean_score       = out_mean_q;
  assign out_o.overlap_overflow = out_ovf_q;

endmodule

// File: rtl/core/interval_overlap_mean_sweep.sv
// Sweep over sorted interval endpoints that emits overlap pieces with their mean
// score. The front end takes one endpoint per cycle: it merges equal endpoints,
// keeps the running overlap count and score total and decides whether a piece
// closes. Closed pieces wait in a two-entry queue for the back end, whose
// restoring divider produces one quotient bit per cycle; each piece passes
// through fetch, 48 divide steps and hand-over there. Endpoints that
// close no piece pass at one per cycle; when pieces arrive faster than the
// divider drains them, the queue fills and input ready drops until a slot frees.
module interval_overlap_mean_sweep import iom_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  iom_in_if.sink    in_i,
  iom_out_if.source out_o
);

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  iom_job_t push_job;
  iom_job_t pop_job;

  // Endpoint classification and running overlap
  iom_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // Pieces awaiting the divider
  iom_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  // Mean computation and output register
  iom_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  // Queue never written when full or read when empty
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("piece queue overrun");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("piece queue underrun");
  // A queued piece carries a non-zero overlap count
  a_nonzero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.count != '0)) else $error("piece with zero overlap");
`endif

endmodule
